// ===== src/dawe_pkg.sv =====
// ----------------------------------------------------------------------------
// dawe_pkg
// Shared types and constants for the DNS address wire encoder.
// ----------------------------------------------------------------------------
package dawe_pkg;

  localparam int LABEL_MAX    = 32;
  localparam int LABEL_CAP    = (LABEL_MAX < 61) ? LABEL_MAX : 61;
  localparam int COUNT_W      = 6;
  localparam int LABEL_ADDR_W = (LABEL_CAP > 1) ? $clog2(LABEL_CAP) : 1;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       address_done;
    logic       error_flag;
  } out_item_t;

endpackage

// ===== src/dns_address_wire_encoder.sv =====
// ----------------------------------------------------------------------------
// dns_address_wire_encoder
// Encodes an address, one character per transfer, into DNS wire bytes:
// dotted IPv4 octets or length-prefixed name labels with a terminator.
// ----------------------------------------------------------------------------
//  channel  signals                     payload
//  in       in_valid / in_ready         in_data  (char_in, last_char)
//  out      out_valid / out_ready       out_data (out_byte, run_last,
//                                                 address_done, error_flag)
//
//  A character that produces no byte leaves in_ready high. in_ready is low
//  while results are sequenced, one byte per cycle while out_ready is high.
//  A label flushes as its length byte, then its characters, read one entry
//  per cycle while out_ready is high, from the label RAM (registered read).
//  Reset (rst, synchronous) returns to the start of an address; no RAM clear.
//  Stalls on out hold the sequencer and the pending RAM read data.
// ----------------------------------------------------------------------------
module dns_address_wire_encoder
  import dawe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_OCT1, ST_OCT2, ST_LEN, ST_CHAR, ST_EMPTY, ST_TERM
  } state_t;

  state_t             state;
  logic               at_start;
  logic               ip_mode;
  logic [COUNT_W-1:0] label_count;
  logic [7:0]         octet_accum;
  logic               digits_stopped;
  logic               piece_has_digit;
  logic               sticky_error;

  logic [COUNT_W-1:0] flush_len;
  logic [COUNT_W-1:0] char_idx;
  logic               flush_err;
  logic               more_after;
  logic               extra_empty;
  logic [7:0]         oct_byte;
  logic               oct_two;
  logic               addr_end;

  logic               push;
  logic               push_ready;
  logic               fire;
  out_item_t          push_data;

  logic                    ram_we;
  logic [LABEL_ADDR_W-1:0] ram_waddr;
  logic                    ram_re;
  logic [LABEL_ADDR_W-1:0] ram_raddr;
  logic [7:0]              ram_rdata;

  logic               accept;
  logic               is_digit;
  logic               is_dot;
  logic               mode_ip;
  logic [3:0]         digit_val;
  logic [10:0]        accum_x10;
  logic [7:0]         accum_upd;
  logic               has_upd;
  logic               stopped_upd;
  logic [7:0]         oct_val;
  logic               oct_err_v;
  logic               room;
  logic [COUNT_W-1:0] count_upd;
  logic               sticky_name;
  logic [COUNT_W-1:0] idx_inc;
  logic               char_final;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_digit  = (in_data.char_in >= CHAR_ZERO) && (in_data.char_in <= CHAR_NINE);
    is_dot    = (in_data.char_in == CHAR_DOT);
    mode_ip   = at_start ? is_digit : ip_mode;
    digit_val = 4'(in_data.char_in - CHAR_ZERO);
    accum_x10 = {octet_accum, 3'b000} + {2'b00, octet_accum, 1'b0};

    accum_upd   = octet_accum;
    has_upd     = piece_has_digit;
    stopped_upd = digits_stopped;
    if (!is_dot && !digits_stopped) begin
      if (is_digit) begin
        accum_upd = accum_x10[7:0] + {4'b0000, digit_val};
        has_upd   = 1'b1;
      end else begin
        stopped_upd = 1'b1;
      end
    end
    oct_val   = has_upd ? accum_upd : 8'h00;
    oct_err_v = sticky_error || !has_upd;

    room        = (label_count < COUNT_W'(LABEL_CAP));
    count_upd   = room ? label_count + COUNT_W'(1) : label_count;
    sticky_name = sticky_error || (!is_dot && !room);

    ram_we    = accept && !mode_ip && !is_dot && room;
    ram_waddr = label_count[LABEL_ADDR_W-1:0];
  end

  always_comb begin
    idx_inc    = char_idx + COUNT_W'(1);
    char_final = (idx_inc == flush_len);
    push       = 1'b0;
    push_data  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    case (state)
      ST_OCT1: begin
        push      = 1'b1;
        push_data = '{out_byte: oct_byte, run_last: !oct_two,
                      address_done: addr_end && !oct_two, error_flag: flush_err};
      end
      ST_OCT2: begin
        push      = 1'b1;
        push_data = '{out_byte: 8'h00, run_last: 1'b1,
                      address_done: 1'b1, error_flag: 1'b1};
      end
      ST_LEN: begin
        push      = 1'b1;
        push_data = '{out_byte: 8'(flush_len),
                      run_last: (flush_len == '0) && !more_after,
                      address_done: 1'b0, error_flag: flush_err};
        ram_re    = push_ready && (flush_len != '0);
      end
      ST_CHAR: begin
        push      = 1'b1;
        push_data = '{out_byte: ram_rdata, run_last: char_final && !more_after,
                      address_done: 1'b0, error_flag: flush_err};
        ram_re    = push_ready && !char_final;
        ram_raddr = idx_inc[LABEL_ADDR_W-1:0];
      end
      ST_EMPTY: begin
        push      = 1'b1;
        push_data = '{out_byte: 8'h00, run_last: 1'b0,
                      address_done: 1'b0, error_flag: flush_err};
      end
      ST_TERM: begin
        push      = 1'b1;
        push_data = '{out_byte: 8'h00, run_last: 1'b1,
                      address_done: 1'b1, error_flag: flush_err};
      end
      default: begin
        push = 1'b0;
      end
    endcase
    fire = push && push_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      at_start        <= 1'b1;
      ip_mode         <= 1'b0;
      label_count     <= '0;
      octet_accum     <= '0;
      digits_stopped  <= 1'b0;
      piece_has_digit <= 1'b0;
      sticky_error    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            at_start <= 1'b0;
            ip_mode  <= mode_ip;
            if (mode_ip) begin
              if (is_dot || in_data.last_char) begin
                oct_byte        <= oct_val;
                flush_err       <= oct_err_v;
                oct_two         <= is_dot && in_data.last_char;
                addr_end        <= in_data.last_char;
                octet_accum     <= '0;
                digits_stopped  <= 1'b0;
                piece_has_digit <= 1'b0;
                sticky_error    <= oct_err_v;
                state           <= ST_OCT1;
              end else begin
                octet_accum     <= accum_upd;
                digits_stopped  <= stopped_upd;
                piece_has_digit <= has_upd;
              end
            end else begin
              flush_err    <= sticky_name;
              sticky_error <= sticky_name;
              if (is_dot || in_data.last_char) begin
                flush_len   <= is_dot ? label_count : count_upd;
                extra_empty <= is_dot && in_data.last_char;
                more_after  <= in_data.last_char;
                label_count <= '0;
                state       <= ST_LEN;
              end else begin
                label_count <= count_upd;
              end
            end
            if (in_data.last_char) begin
              at_start     <= 1'b1;
              ip_mode      <= 1'b0;
              sticky_error <= 1'b0;
            end
          end
        end
        ST_OCT1: begin
          if (fire) begin
            state <= oct_two ? ST_OCT2 : ST_IDLE;
          end
        end
        ST_LEN: begin
          if (fire) begin
            char_idx <= '0;
            if (flush_len != '0) begin
              state <= ST_CHAR;
            end else if (extra_empty) begin
              state <= ST_EMPTY;
            end else if (more_after) begin
              state <= ST_TERM;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_CHAR: begin
          if (fire) begin
            char_idx <= idx_inc;
            if (!char_final) begin
              state <= ST_CHAR;
            end else if (extra_empty) begin
              state <= ST_EMPTY;
            end else if (more_after) begin
              state <= ST_TERM;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMPTY: begin
          if (fire) begin
            state <= ST_TERM;
          end
        end
        ST_OCT2, ST_TERM: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  dawe_label_ram #(
    .DEPTH  (LABEL_CAP),
    .DATA_W (8),
    .ADDR_W (LABEL_ADDR_W)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.char_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dawe_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== src/dawe_label_ram.sv =====
// ----------------------------------------------------------------------------
// dawe_label_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dawe_label_ram #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/dawe_out_stage.sv =====
// ----------------------------------------------------------------------------
// dawe_out_stage
// Output register between the encoder sequencer and the result channel.
// ----------------------------------------------------------------------------
module dawe_out_stage
  import dawe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      push_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  assign push_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_ready) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      out_data <= push_data;
    end
  end

endmodule

// ===== test/dns_address_wire_encoder_test.sv =====
// ----------------------------------------------------------------------------
// dns_address_wire_encoder_test
// Sends addresses into the encoder one character per transfer: first a short
// table of hand-picked addresses, then random dotted IPv4 addresses, DNS names
// and junk text. Idle gaps fall at random on both sides. A behavioral encoder
// predicts bytes unless a row pins them; each transfer is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dns_address_wire_encoder_test;
  import dawe_pkg::*;

  localparam int RANDOM_ITEMS  = 500;
  localparam int PRESSURE_HOLD = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int DRILL_ROWS    = 25;
  localparam logic [7:0] ROOT_LABEL = 8'h00;
  localparam out_item_t  NO_ANSWER  = '0;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    int         reps;
    bit         pinned;
    out_item_t  answer;
  } drill_row_t;

  typedef struct {
    bit        on;
    out_item_t res;
  } pinned_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // encoder state mirror
  bit         at_start;
  bit         ip_mode;
  logic [7:0] label_buf [LABEL_CAP];
  int         label_len;
  logic [7:0] octet;
  bit         digits_stopped;
  bit         piece_has_digit;
  bit         sticky_err;

  out_item_t step_q[$];
  out_item_t wire_bytes_q[$];
  pinned_t   pinned_q[$];
  in_item_t  text_q[$];

  int mismatches  = 0;
  int bytes_taken = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;

  drill_row_t drill [DRILL_ROWS] = '{
    '{"7",      1'b1, 1,             1'b1, '{8'd7,   1'b1, 1'b1, 1'b0}},
    '{"2",      1'b0, 1,             1'b0, NO_ANSWER},
    '{"5",      1'b0, 1,             1'b0, NO_ANSWER},
    '{"5",      1'b1, 1,             1'b1, '{8'd255, 1'b1, 1'b1, 1'b0}},
    '{"2",      1'b0, 1,             1'b0, NO_ANSWER},
    '{"5",      1'b0, 1,             1'b0, NO_ANSWER},
    '{"6",      1'b1, 1,             1'b1, '{8'd0,   1'b1, 1'b1, 1'b0}},
    '{"1",      1'b0, 1,             1'b0, NO_ANSWER},
    '{"x",      1'b0, 1,             1'b0, NO_ANSWER},
    '{"5",      1'b0, 1,             1'b0, NO_ANSWER},
    '{CHAR_DOT, 1'b0, 1,             1'b0, NO_ANSWER},
    '{CHAR_DOT, 1'b1, 1,             1'b0, NO_ANSWER},
    '{CHAR_DOT, 1'b1, 1,             1'b0, NO_ANSWER},
    '{"a",      1'b0, 1,             1'b0, NO_ANSWER},
    '{"9",      1'b0, 1,             1'b0, NO_ANSWER},
    '{CHAR_DOT, 1'b0, 1,             1'b0, NO_ANSWER},
    '{CHAR_DOT, 1'b0, 1,             1'b0, NO_ANSWER},
    '{8'hFF,    1'b0, 1,             1'b0, NO_ANSWER},
    '{8'h00,    1'b1, 1,             1'b0, NO_ANSWER},
    '{"z",      1'b0, LABEL_CAP + 2, 1'b0, NO_ANSWER},
    '{CHAR_DOT, 1'b0, 1,             1'b0, NO_ANSWER},
    '{"q",      1'b1, 1,             1'b0, NO_ANSWER},
    '{"0",      1'b1, 1,             1'b1, '{8'd0,   1'b1, 1'b1, 1'b0}},
    '{"9",      1'b0, 1,             1'b0, NO_ANSWER},
    '{CHAR_DOT, 1'b1, 1,             1'b0, NO_ANSWER}
  };

  dns_address_wire_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_encoder();
    at_start        = 1'b1;
    ip_mode         = 1'b0;
    label_len       = 0;
    octet           = '0;
    digits_stopped  = 1'b0;
    piece_has_digit = 1'b0;
    sticky_err      = 1'b0;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    step_q.insert(step_q.size(), out_item_t'{b, 1'b0, 1'b0, sticky_err});
  endfunction

  function automatic void flush_label();
    emit_byte(8'(label_len));
    for (int i = 0; i < label_len; i++) emit_byte(label_buf[i]);
    label_len = 0;
  endfunction

  function automatic void flush_octet();
    if (!piece_has_digit) sticky_err = 1'b1;
    emit_byte(piece_has_digit ? octet : 8'h00);
    octet           = '0;
    digits_stopped  = 1'b0;
    piece_has_digit = 1'b0;
  endfunction

  function automatic void encode_char(in_item_t it);
    bit is_digit;
    is_digit = (it.char_in >= CHAR_ZERO) && (it.char_in <= CHAR_NINE);
    if (at_start) begin
      ip_mode  = is_digit;
      at_start = 1'b0;
    end
    if (ip_mode) begin
      if (it.char_in == CHAR_DOT) begin
        flush_octet();
      end else if (!digits_stopped) begin
        if (is_digit) begin
          octet           = 8'(octet * 10 + (it.char_in - CHAR_ZERO));
          piece_has_digit = 1'b1;
        end else begin
          digits_stopped = 1'b1;
        end
      end
      if (it.last_char) flush_octet();
    end else begin
      if (it.char_in == CHAR_DOT) begin
        flush_label();
      end else if (label_len < LABEL_CAP) begin
        label_buf[label_len] = it.char_in;
        label_len++;
      end else begin
        sticky_err = 1'b1;
      end
      if (it.last_char) begin
        flush_label();
        emit_byte(ROOT_LABEL);
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
    if (it.last_char) begin
      step_q[step_q.size() - 1].address_done = 1'b1;
      clear_encoder();
    end
  endfunction

  function automatic void log_mismatch(string why, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte %02h last %b done %b err %b",
               $realtime, why, want.out_byte, want.run_last, want.address_done,
               want.error_flag);
      $display("%0t: %s: actual   byte %02h last %b done %b err %b",
               $realtime, why, got.out_byte, got.run_last, got.address_done,
               got.error_flag);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] label_char();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: return 8'(CHAR_ZERO + $urandom_range(0, 9));
      1: return 8'h2D;
      2: begin
        b = 8'($urandom_range(0, 255));
        return (b == CHAR_DOT) ? 8'h5F : b;
      end
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic void add_char(logic [7:0] b);
    text_q.insert(text_q.size(), in_item_t'{b, 1'b0});
  endfunction

  function automatic void compose_address();
    int kind;
    int parts;
    int len;
    int r;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      parts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
      for (int p = 0; p < parts; p++) begin
        if (p > 0) add_char(CHAR_DOT);
        r = $urandom_range(0, 19);
        if (r == 1) add_char(8'($urandom_range(8'h3A, 8'h7E)));
        len = (r == 0) ? 0 : (r == 2) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        repeat (len) add_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 14) == 0) add_char(8'($urandom_range(8'h3A, 8'h7E)));
      end
    end else if (kind < 85) begin
      parts = $urandom_range(1, 4);
      for (int p = 0; p < parts; p++) begin
        if (p > 0) add_char(CHAR_DOT);
        r = $urandom_range(0, 29);
        len = (r == 0) ? $urandom_range(LABEL_CAP + 1, LABEL_CAP + 8) :
              (r == 1) ? LABEL_CAP :
              (r == 2) ? 0 : $urandom_range(1, 10);
        repeat (len) add_char(label_char());
      end
      if ($urandom_range(0, 7) == 0) add_char(CHAR_DOT);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        add_char(($urandom_range(0, 3) == 0) ? CHAR_DOT : 8'($urandom_range(0, 255)));
      end
    end
    if (text_q.size() == 0) add_char(CHAR_DOT);
    text_q[text_q.size() - 1].last_char = 1'b1;
  endfunction

  task automatic offer_char(in_item_t it, bit pin, out_item_t pin_res);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    pinned_q.insert(pinned_q.size(), pinned_t'{pin, pin_res});
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    pinned_t   fix;
    out_item_t want;
    bit        moved;
    moved = 1'b0;
    if (rst) begin
      clear_encoder();
    end else begin
      if (in_valid && in_ready) begin
        moved = 1'b1;
        step_q.delete();
        encode_char(in_data);
        fix = pinned_q.pop_front();
        if (fix.on) begin
          step_q.delete();
          step_q.insert(step_q.size(), fix.res);
        end
        foreach (step_q[i]) wire_bytes_q.insert(wire_bytes_q.size(), step_q[i]);
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        bytes_taken++;
        if (wire_bytes_q.size() == 0) begin
          log_mismatch("unexpected transfer", NO_ANSWER, out_data);
        end else begin
          want = wire_bytes_q.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.run_last !== want.run_last ||
              out_data.address_done !== want.address_done ||
              out_data.error_flag !== want.error_flag) begin
            log_mismatch("wrong byte", want, out_data);
          end
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    int run;
    int hold;
    bit pressed;
    pressed   = 1'b0;
    out_ready = 1'b0;
    forever begin
      if (!pressed && bytes_taken >= 200) begin
        pressed = 1'b1;
        out_ready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
      end
      run = calm ? 50 : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      hold = calm ? 0 : pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("dns_address_wire_encoder_test NOT OK");
    $finish;
  end

  initial begin
    int sent;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (drill[r]) begin
      for (int k = 0; k < drill[r].reps; k++) begin
        offer_char('{drill[r].ch, drill[r].last}, drill[r].pinned, drill[r].answer);
      end
    end
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      compose_address();
      foreach (text_q[i]) offer_char(text_q[i], 1'b0, NO_ANSWER);
      sent += text_q.size();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (wire_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && wire_bytes_q.size() == 0) begin
      $display("dns_address_wire_encoder_test OK");
    end else begin
      $display("dns_address_wire_encoder_test NOT OK");
    end
    $finish;
  end

endmodule
